// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define TSPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define TSPF_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tspf_pkg.sv -----
// types and constants of the transport stream packet filter
`default_nettype none
package tspf_pkg;

  localparam int unsigned REG_COUNT = 6;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned PID_W     = 13;
  localparam int unsigned SPID_W    = 14;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] PKT_LAST   = 8'd187;
  localparam logic [7:0] PKT_BYTES  = 8'd188;
  localparam logic [7:0] AF_LEN_MAX = 8'd183;
  localparam logic [7:0] HDR_BYTES  = 8'd4;
  localparam logic [7:0] AF_BASE    = 8'd5;

  localparam logic [SPID_W-1:0] PID_SLOT0_RST = 14'd0;
  localparam logic [SPID_W-1:0] PID_NONE      = 14'd8192;
  localparam logic [4:0]        CNT_NONE      = 5'd16;

  typedef enum logic [2:0] {
    V_FORWARD   = 3'd0,
    V_NOPAYLOAD = 3'd1,
    V_BADSYNC   = 3'd2,
    V_OVERRUN   = 3'd3,
    V_UNKNOWN   = 3'd4,
    V_ERROR     = 3'd5,
    V_SCRAMBLED = 3'd6,
    V_DUPLICATE = 3'd7
  } verdict_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_t;

  typedef struct packed {
    logic              valid;
    logic [7:0]        payload_byte;
    logic [SLOT_W-1:0] slot_index;
    logic              has_data;
    logic              unit_start;
    logic              packet_done;
    verdict_t          verdict;
    logic              flush_request;
  } result_t;

endpackage
`default_nettype wire

// ----- src/tspf_slot_table.sv -----
// slot pid registers and first-match pid lookup
`default_nettype none
module tspf_slot_table #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [tspf_pkg::CFG_IDX_W-1:0] wr_idx,
  input  wire [tspf_pkg::SPID_W-1:0]    wr_data,
  input  wire [tspf_pkg::PID_W-1:0]     pid,
  output tspf_pkg::match_t             match
);
  import tspf_pkg::*;

  logic [SPID_W-1:0] slot_pid_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        slot_pid_r[i] <= (i == 0) ? PID_SLOT0_RST : PID_NONE;
      end
    end else if (wr_en) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (wr_idx == CFG_IDX_W'(i)) begin
          slot_pid_r[i] <= wr_data;
        end
      end
    end
  end

  // lowest matching slot wins
  always_comb begin
    match = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_pid_r[i] == {1'b0, pid}) begin
        match.hit  = 1'b1;
        match.slot = SLOT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/tspf_parse.sv -----
// packet header parse, verdict, continuity counters and result forming
`default_nettype none
module tspf_parse #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      step_en,
  input  wire [7:0]                data_byte,
  input  wire                      chunk_start,
  input  tspf_pkg::match_t         match,
  output logic [tspf_pkg::PID_W-1:0] pid,
  output tspf_pkg::result_t        res
);
  import tspf_pkg::*;

  logic [7:0]        pos_r, pos_nxt;
  logic [23:0]       hdr_r, hdr_nxt;
  logic [7:0]        pstart_r, pstart_nxt;
  logic [SLOT_W-1:0] mslot_r, mslot_nxt;
  verdict_t          verdict_r, verdict_nxt;
  logic [4:0]        last_cnt_r [NUM_SLOTS];

  logic [7:0]  p;
  logic [23:0] hdr_shift, hdr_dec;
  logic [7:0]  ps_dec;
  logic        dec_go, dec_over;
  logic [4:0]  cnt_sel;
  logic        data, ustart, done, accepted, commit;

  assign p         = chunk_start ? 8'd0 : pos_r;
  assign hdr_shift = {hdr_r[15:0], data_byte};
  assign pid       = (p == 8'd3) ? hdr_shift[20:8] : hdr_r[20:8];

  always_comb begin
    cnt_sel = CNT_NONE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (match.slot == SLOT_W'(i)) begin
        cnt_sel = last_cnt_r[i];
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    pstart_nxt  = pstart_r;
    mslot_nxt   = mslot_r;
    verdict_nxt = verdict_r;
    dec_go      = 1'b0;
    dec_over    = 1'b0;
    hdr_dec     = hdr_r;
    ps_dec      = pstart_r;
    data        = 1'b0;
    ustart      = 1'b0;

    if (p == 8'd0) begin
      hdr_nxt     = '0;
      mslot_nxt   = '0;
      pstart_nxt  = HDR_BYTES;
      verdict_nxt = (data_byte == SYNC_BYTE) ? V_FORWARD : V_BADSYNC;
    end else if (p <= 8'd3) begin
      hdr_nxt = hdr_shift;
      if (p == 8'd3 && verdict_r != V_BADSYNC && !hdr_shift[5]) begin
        dec_go  = 1'b1;
        hdr_dec = hdr_shift;
      end
    end else if (p == 8'd4 && verdict_r != V_BADSYNC && hdr_r[5]) begin
      dec_go     = 1'b1;
      dec_over   = data_byte > AF_LEN_MAX;
      pstart_nxt = dec_over ? PKT_BYTES : AF_BASE + data_byte;
      ps_dec     = pstart_nxt;
    end

    if (dec_go) begin
      if (dec_over) begin
        verdict_nxt = V_OVERRUN;
      end else if (!match.hit) begin
        mslot_nxt   = '0;
        verdict_nxt = V_UNKNOWN;
      end else begin
        mslot_nxt = match.slot;
        if (hdr_dec[23]) begin
          verdict_nxt = V_ERROR;
        end else if (hdr_dec[7:6] != 2'b00) begin
          verdict_nxt = V_SCRAMBLED;
        end else if ({1'b0, hdr_dec[3:0]} == cnt_sel) begin
          verdict_nxt = V_DUPLICATE;
        end else if (!hdr_dec[4] || ps_dec >= PKT_BYTES) begin
          verdict_nxt = V_NOPAYLOAD;
        end else begin
          verdict_nxt = V_FORWARD;
        end
      end
    end

    if (p >= HDR_BYTES && verdict_nxt == V_FORWARD && hdr_r[4] && p >= pstart_nxt) begin
      data   = 1'b1;
      ustart = (p == pstart_nxt) && hdr_r[22];
    end

    done     = (p == PKT_LAST);
    accepted = (verdict_nxt == V_FORWARD) || (verdict_nxt == V_NOPAYLOAD);
    commit   = done && accepted;
    pos_nxt  = done ? 8'd0 : p + 8'd1;

    res.valid         = data || done;
    res.payload_byte  = data ? data_byte : 8'd0;
    res.slot_index    = mslot_nxt;
    res.has_data      = data;
    res.unit_start    = ustart;
    res.packet_done   = done;
    res.verdict       = done ? verdict_nxt : V_FORWARD;
    res.flush_request = commit && hdr_nxt[22];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hdr_r     <= '0;
      pstart_r  <= '0;
      mslot_r   <= '0;
      verdict_r <= V_FORWARD;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        last_cnt_r[i] <= CNT_NONE;
      end
    end else if (step_en) begin
      pos_r     <= pos_nxt;
      hdr_r     <= hdr_nxt;
      pstart_r  <= pstart_nxt;
      mslot_r   <= mslot_nxt;
      verdict_r <= verdict_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (commit && mslot_nxt == SLOT_W'(i)) begin
          last_cnt_r[i] <= {1'b0, hdr_nxt[3:0]};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/transport_stream_packet_filter_core.sv -----
// top level of the transport stream packet filter
`default_nettype none
// Filters a byte stream of 188-byte transport packets, one byte per word. Each
// accepted byte passes an input register, one pass of header parse, pid lookup
// against the slot table and continuity check, and lands in a result register,
// so a byte can be taken every cycle while in_stall is low, and its result word
// is on the output from the result register. in_stall is raised only while a
// result word waits under out_stall and the byte in the input register has a
// result of its own. A byte gives at most one result word: a forwarded payload
// byte, the packet verdict on the last byte of a packet, or both. Bytes that give
// no result leave nothing on the output. The slot pid registers are written
// through the cfg port, which is always ready and takes effect at once; write
// it only while no bytes are in flight. Slots at or above NUM_SLOTS never match.
module transport_stream_packet_filter_core #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [7:0]                     in_data_byte,
  input  wire                           in_chunk_start,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [7:0]                    out_payload_byte,
  output logic [tspf_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_has_data,
  output logic                          out_unit_start,
  output logic                          out_packet_done,
  output logic [2:0]                    out_verdict,
  output logic                          out_flush_request,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [tspf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [tspf_pkg::SPID_W-1:0]    cfg_data
);
  import tspf_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_cs_r;
  logic         s1_adv;
  logic         out_valid_r;
  result_t      res, res_r;
  match_t       match;
  logic [PID_W-1:0] pid;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!res.valid || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;

  tspf_slot_table #(.NUM_SLOTS(NUM_SLOTS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(REG_COUNT)),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .pid     (pid),
    .match   (match)
  );

  tspf_parse #(.NUM_SLOTS(NUM_SLOTS)) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .data_byte   (s1_byte_r),
    .chunk_start (s1_cs_r),
    .match       (match),
    .pid         (pid),
    .res         (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_cs_r   <= in_chunk_start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_slot_index    = res_r.slot_index;
  assign out_has_data      = res_r.has_data;
  assign out_unit_start    = res_r.unit_start;
  assign out_packet_done   = res_r.packet_done;
  assign out_verdict       = res_r.verdict;
  assign out_flush_request = res_r.flush_request;

endmodule
`default_nettype wire

// ----- src/tspf_checker.sv -----
// port-level checks of the packet filter and their bind
`default_nettype none
`include "assert_macros.svh"
module tspf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_has_data,
  input wire       out_unit_start,
  input wire       out_packet_done,
  input wire [2:0] out_verdict,
  input wire       out_flush_request
);
  import tspf_pkg::*;

  logic mid_word, last_data_word, start_word, flush_word;
  logic fwd_verdict, acc_done;

  assign mid_word       = out_valid && !out_packet_done;
  assign last_data_word = out_valid && out_has_data && out_packet_done;
  assign start_word     = out_valid && out_unit_start;
  assign flush_word     = out_valid && out_flush_request;
  assign fwd_verdict    = out_verdict == V_FORWARD;
  assign acc_done       = out_packet_done && (fwd_verdict || out_verdict == V_NOPAYLOAD);

  `TSPF_ASSERT_ALL(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `TSPF_ASSERT(a_verdict_only_on_done, mid_word |-> fwd_verdict, "verdict without packet end")
  `TSPF_ASSERT(a_data_needs_forward, last_data_word |-> fwd_verdict, "payload on dropped packet")
  `TSPF_ASSERT(a_start_needs_data, start_word |-> out_has_data, "unit start without payload")
  `TSPF_ASSERT(a_flush_accepted, flush_word |-> acc_done, "flush on rejected packet")

endmodule

bind transport_stream_packet_filter_core tspf_checker u_tspf_checker (.*);
`default_nettype wire
